// ----- rtl/swr_pkg.sv -----
// Package with widths, register indexes, state codes and result type of the window receiver.
`timescale 1ns / 1ps

package swr_pkg;

  localparam int SEQ_SLOTS = 32;
  localparam int SEQ_W     = $clog2(SEQ_SLOTS);
  localparam int RNG_W     = $clog2(SEQ_SLOTS + 1);
  localparam int WIN_W     = 4;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;

  localparam logic [RNG_W-1:0] RANGE_MIN   = RNG_W'(3);
  localparam logic [RNG_W-1:0] RANGE_MAX   = RNG_W'(SEQ_SLOTS);
  localparam logic [RNG_W-1:0] RANGE_RESET = RNG_W'(20);
  localparam logic [WIN_W-1:0] WIN_RESET   = WIN_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GO_BACK_N = 2'd0,
    CFG_WINDOW    = 2'd1,
    CFG_RANGE     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WALK,
    ST_DONE,
    ST_OUT,
    ST_REALIGN
  } state_e;

  typedef struct packed {
    logic             ack_valid;
    logic [SEQ_W-1:0] ack_seq;
    logic             stored;
    logic [WIN_W-1:0] slots_released;
    logic [SEQ_W-1:0] window_base_out;
    logic             transfer_done;
    logic [CNT_W-1:0] original_count;
    logic [CNT_W-1:0] repeat_count;
  } result_t;

endpackage

// ----- rtl/swr_intf.sv -----
// Handshake interfaces for the frame, acknowledgement and configuration channels.
`timescale 1ns / 1ps

interface swr_frame_if;
  import swr_pkg::*;
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] frame_seq;
  logic             frame_good;
  logic             final_frame;

  modport source (output valid, frame_seq, frame_good, final_frame, input ready);
  modport sink   (input valid, frame_seq, frame_good, final_frame, output ready);
endinterface

interface swr_ack_if;
  import swr_pkg::*;
  logic             valid;
  logic             ready;
  logic             ack_valid;
  logic [SEQ_W-1:0] ack_seq;
  logic             stored;
  logic [WIN_W-1:0] slots_released;
  logic [SEQ_W-1:0] window_base_out;
  logic             transfer_done;
  logic [CNT_W-1:0] original_count;
  logic [CNT_W-1:0] repeat_count;

  modport source (output valid, ack_valid, ack_seq, stored, slots_released,
                  window_base_out, transfer_done, original_count, repeat_count,
                  input ready);
  modport sink   (input valid, ack_valid, ack_seq, stored, slots_released,
                  window_base_out, transfer_done, original_count, repeat_count,
                  output ready);
endinterface

interface swr_cfg_if;
  import swr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/sliding_window_receiver.sv -----
// Receiver window of a selective-repeat / go-back-N link, built around one modular add unit.
//
// Usage: frame_i carries one frame header per word (sequence number, checksum
// status, last-frame flag). For each accepted word exactly one result word
// leaves on ack_o: whether to acknowledge and with which number, whether the
// frame was stored, how many slots the window slid, the new window base, the
// sticky done flag and two saturating frame counters. cfg_i writes the mode
// (index 0), the window size (index 1) and the sequence range (index 2).
// An accepted frame is first decided; then the window walk moves the base one
// slot per cycle through the shared modular adder, releasing 0 to 15 slots,
// and then the result is registered for ack_o. The next frame is taken the
// cycle after the result is registered, so no new frame is taken while one
// is still being handled. On a configuration write the base is reduced into
// the new range by one subtraction per cycle; no frame is taken meanwhile.
// Reset clears the slot map, base, counters and done flag, and loads
// the default registers (selective repeat, window of 7, range of 20). When the
// downstream stalls, the result stays in the output register and the block
// still accepts the next frame; it waits only when a second result is ready.
`timescale 1ns / 1ps

module sliding_window_receiver (
  input  logic      clk_i,
  input  logic      rst_ni,
  swr_frame_if.sink frame_i,
  swr_cfg_if.sink   cfg_i,
  swr_ack_if.source ack_o
);
  import swr_pkg::*;

  // Configuration registers.
  logic             gbn_q;
  logic [WIN_W-1:0] win_q;
  logic [RNG_W-1:0] range_q;

  // Window state. The window top is always base plus span modulo the range,
  // so only the span is kept.
  logic [SEQ_SLOTS-1:0] map_q;
  logic [SEQ_W-1:0]     base_q;
  logic [WIN_W-1:0]     span_q;
  logic [SEQ_W-1:0]     final_seq_q;
  logic                 final_seen_q;
  logic                 done_q;
  logic [CNT_W-1:0]     orig_q;
  logic [CNT_W-1:0]     rep_q;

  // Frame under work and its partial result.
  logic [SEQ_W-1:0] seq_q;
  logic             good_q;
  logic             fin_q;
  logic             ack_valid_q;
  logic [SEQ_W-1:0] ack_seq_q;
  logic             stored_q;
  logic [WIN_W-1:0] released_q;

  result_t res_q;
  logic    out_valid_q;

  state_e state_q, state_d;

  // Effective range and window.
  logic [RNG_W-1:0] r_eff;
  logic [WIN_W-1:0] w_raw, w_lim, w_eff;
  logic [SEQ_SLOTS-1:0] range_mask;

  always_comb begin
    if (range_q < RANGE_MIN) begin
      r_eff = RANGE_MIN;
    end else if (range_q > RANGE_MAX) begin
      r_eff = RANGE_MAX;
    end else begin
      r_eff = range_q;
    end
    w_raw = gbn_q ? WIN_W'(1) : win_q;
    if (w_raw == '0) begin
      w_raw = WIN_W'(1);
    end
    w_lim = WIN_W'((r_eff - RNG_W'(1)) >> 1);
    w_eff = (w_raw > w_lim) ? w_lim : w_raw;
    for (int i = 0; i < SEQ_SLOTS; i++) begin
      range_mask[i] = (RNG_W'(i) < r_eff);
    end
  end

  // Shared modular add/subtract unit. Both operands lie below the range,
  // except during realignment where a >= b gives a plain difference.
  logic             u_sub;
  logic [RNG_W-1:0] u_a, u_b, u_res;
  logic [RNG_W:0]   u_diff, u_sum;

  always_comb begin
    u_diff = {1'b0, u_a} - {1'b0, u_b};
    u_sum  = {1'b0, u_a} + {1'b0, u_b};
    if (u_sub) begin
      u_res = u_diff[RNG_W] ? RNG_W'(u_diff + {1'b0, r_eff}) : u_diff[RNG_W-1:0];
    end else begin
      u_res = (u_sum >= {1'b0, r_eff}) ? RNG_W'(u_sum - {1'b0, r_eff})
                                       : u_sum[RNG_W-1:0];
    end
  end

  // Single port into the slot map: the frame's slot while deciding, the base
  // slot while walking.
  logic [SEQ_W-1:0] map_idx;
  logic             map_bit;
  assign map_idx = (state_q == ST_DECIDE) ? seq_q : base_q;
  assign map_bit = map_q[map_idx];

  logic frame_acc, cfg_acc, out_free, walk_go;
  assign frame_acc = frame_i.valid && frame_i.ready;
  assign cfg_acc   = cfg_i.valid && cfg_i.ready;
  assign out_free  = !out_valid_q || ack_o.ready;
  assign walk_go   = (released_q < w_eff) && map_bit;

  // Window test of the unit's offset against the span.
  logic             in_win;
  logic             have;
  logic [SEQ_W-1:0] gbn_ack;
  assign in_win  = ({1'b0, seq_q} < r_eff) && (u_res <= RNG_W'(span_q));
  assign have    = in_win && map_bit;
  assign gbn_ack = (base_q == '0) ? SEQ_W'(r_eff - RNG_W'(1)) : (base_q - SEQ_W'(1));

  logic fin_inside;
  assign fin_inside = ({1'b0, final_seq_q} < r_eff) && (u_res <= RNG_W'(span_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          state_d = ST_REALIGN;
        end else if (frame_acc) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: state_d = ST_WALK;
      ST_WALK: begin
        if (!walk_go) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_REALIGN: begin
        if ({1'b0, base_q} < r_eff) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshakes and unit operand selection.
  always_comb begin
    cfg_i.ready   = (state_q == ST_IDLE);
    frame_i.ready = (state_q == ST_IDLE) && !cfg_i.valid;
    u_sub = 1'b1;
    u_a   = {1'b0, seq_q};
    u_b   = {1'b0, base_q};
    case (state_q)
      ST_WALK: begin
        u_sub = 1'b0;
        u_a   = {1'b0, base_q};
        u_b   = RNG_W'(1);
      end
      ST_DONE: begin
        u_a = {1'b0, final_seq_q};
      end
      ST_REALIGN: begin
        u_a = {1'b0, base_q};
        u_b = r_eff;
      end
      default: begin
        u_sub = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      gbn_q        <= 1'b0;
      win_q        <= WIN_RESET;
      range_q      <= RANGE_RESET;
      map_q        <= '0;
      base_q       <= '0;
      span_q       <= WIN_RESET - WIN_W'(1);
      final_seq_q  <= '0;
      final_seen_q <= 1'b0;
      done_q       <= 1'b0;
      orig_q       <= '0;
      rep_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // A new result loads the output register as the old one leaves.
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && ack_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cfg_acc) begin
            case (cfg_idx_e'(cfg_i.index))
              CFG_GO_BACK_N: gbn_q   <= cfg_i.data[0];
              CFG_WINDOW:    win_q   <= cfg_i.data[WIN_W-1:0];
              CFG_RANGE:     range_q <= cfg_i.data[RNG_W-1:0];
              default:       gbn_q   <= gbn_q;
            endcase
          end
        end
        ST_DECIDE: begin
          if (good_q && in_win && !have) begin
            map_q[map_idx] <= 1'b1;
            if (orig_q != '1) begin
              orig_q <= orig_q + CNT_W'(1);
            end
            if (fin_q) begin
              final_seq_q  <= seq_q;
              final_seen_q <= 1'b1;
            end
          end else if (rep_q != '1) begin
            rep_q <= rep_q + CNT_W'(1);
          end
        end
        ST_WALK: begin
          if (walk_go) begin
            map_q[map_idx] <= 1'b0;
            base_q         <= u_res[SEQ_W-1:0];
          end
        end
        ST_DONE: begin
          if (final_seen_q && !fin_inside) begin
            done_q <= 1'b1;
          end
        end
        ST_REALIGN: begin
          if ({1'b0, base_q} >= r_eff) begin
            base_q <= u_res[SEQ_W-1:0];
          end else begin
            span_q <= w_eff - WIN_W'(1);
            map_q  <= map_q & range_mask;
          end
        end
        default: begin
          done_q <= done_q;
        end
      endcase
    end
  end

  // Payload registers of the frame under work and of the result.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (frame_acc) begin
          seq_q  <= frame_i.frame_seq;
          good_q <= frame_i.frame_good;
          fin_q  <= frame_i.final_frame;
        end
      end
      ST_DECIDE: begin
        released_q  <= '0;
        stored_q    <= good_q && in_win && !have;
        ack_valid_q <= !in_win || good_q || have;
        if (in_win) begin
          ack_seq_q <= (good_q || have) ? seq_q : '0;
        end else begin
          ack_seq_q <= gbn_q ? gbn_ack : seq_q;
        end
      end
      ST_WALK: begin
        if (walk_go) begin
          released_q <= released_q + WIN_W'(1);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          res_q.ack_valid       <= ack_valid_q;
          res_q.ack_seq         <= ack_seq_q;
          res_q.stored          <= stored_q;
          res_q.slots_released  <= released_q;
          res_q.window_base_out <= base_q;
          res_q.transfer_done   <= done_q;
          res_q.original_count  <= orig_q;
          res_q.repeat_count    <= rep_q;
        end
      end
      default: begin
        seq_q <= seq_q;
      end
    endcase
  end

  assign ack_o.valid           = out_valid_q;
  assign ack_o.ack_valid       = res_q.ack_valid;
  assign ack_o.ack_seq         = res_q.ack_seq;
  assign ack_o.stored          = res_q.stored;
  assign ack_o.slots_released  = res_q.slots_released;
  assign ack_o.window_base_out = res_q.window_base_out;
  assign ack_o.transfer_done   = res_q.transfer_done;
  assign ack_o.original_count  = res_q.original_count;
  assign ack_o.repeat_count    = res_q.repeat_count;

  // The base stays inside the range while the window walks.
  a_base_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ({1'b0, base_q} < r_eff))
    else $error("window base outside the sequence range during walk");

  // The walk never releases more slots than the window holds.
  a_release_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_DONE) |-> (released_q <= w_eff))
    else $error("window slid past its size");

  // Once raised, the done flag stays.
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("done flag dropped");

  // No slot beyond the range is ever marked while waiting for a frame.
  a_map_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ((map_q & ~range_mask) == '0))
    else $error("slot map holds a mark beyond the range");

  // A stored frame is always acknowledged.
  a_stored_acked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.stored) |-> res_q.ack_valid)
    else $error("stored frame without acknowledgement");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench of the sliding-window ARQ receiver, with its own window predictor.
`timescale 1ns / 1ps

module tb;
  import swr_pkg::*;

  // The slowest stretch without any handshake in a correct run is the receiver
  // hold-off of HOLD_CYCLES. A frame, a register write and the random gaps on
  // either side are short beside it. The limit leaves a wide margin on top of
  // all of that.
  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned PRINT_LIMIT   = 200;

  // The index field has one code past the register list. A write there must be
  // ignored without touching the window.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic clk;
  logic rst_n;

  swr_frame_if frame_if ();
  swr_cfg_if   cfg_if ();
  swr_ack_if   ack_if ();

  sliding_window_receiver DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .frame_i(frame_if),
    .cfg_i  (cfg_if),
    .ack_o  (ack_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted receiver state. It moves forward once per accepted frame word and
  // once per accepted register write, in the order the block sees them.
  logic                 gbn_mode;
  logic [WIN_W-1:0]     win_setting;
  logic [CFG_DAT_W-1:0] range_setting;
  logic [SEQ_SLOTS-1:0] seen_map;
  logic [SEQ_W-1:0]     win_base;
  logic [SEQ_W-1:0]     win_top;
  logic [SEQ_W-1:0]     last_seq;
  logic                 last_seen;
  logic                 done_seen;
  logic [CNT_W-1:0]     stored_total;
  logic [CNT_W-1:0]     repeat_total;

  // Acknowledgement words still owed by the block, oldest first.
  result_t expected_acks[$];

  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off_request;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  // The range register is clamped into 3 .. SEQ_SLOTS before use.
  function automatic int active_range();
    int r;
    r = range_setting;
    if (r < 3) r = 3;
    if (r > SEQ_SLOTS) r = SEQ_SLOTS;
    return r;
  endfunction

  // Go-back-N always runs a window of one. Selective repeat must stay below
  // half the range, otherwise an old frame could alias a new one.
  function automatic int active_window(input int r);
    int w;
    int lim;
    w = gbn_mode ? 1 : int'(win_setting);
    lim = (r - 1) / 2;
    if (w < 1) w = 1;
    if (w > lim) w = lim;
    return w;
  endfunction

  // Circular membership test; a number at or beyond the range is never inside.
  function automatic bit slot_in_window(input int idx, input int r);
    int off;
    int span;
    if (idx >= r) return 1'b0;
    off = (idx + r - int'(win_base)) % r;
    span = (int'(win_top) + r - int'(win_base)) % r;
    return off <= span;
  endfunction

  // After any register change the base is folded into the new range, the top
  // follows the new window size and slots beyond the range are dropped.
  function automatic void realign_window();
    int r;
    int w;
    r = active_range();
    w = active_window(r);
    win_base = SEQ_W'(int'(win_base) % r);
    win_top = SEQ_W'((int'(win_base) + w - 1) % r);
    for (int i = r; i < SEQ_SLOTS; i++) seen_map[i] = 1'b0;
  endfunction

  function automatic void reset_window_model();
    gbn_mode      = 1'b0;
    win_setting   = WIN_RESET;
    range_setting = CFG_DAT_W'(RANGE_RESET);
    seen_map      = '0;
    win_base      = '0;
    last_seq      = '0;
    last_seen     = 1'b0;
    done_seen     = 1'b0;
    stored_total  = '0;
    repeat_total  = '0;
    realign_window();
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_GO_BACK_N: gbn_mode = data[0];
      CFG_WINDOW:    win_setting = data[WIN_W-1:0];
      CFG_RANGE:     range_setting = data;
      default:       return;
    endcase
    realign_window();
  endfunction

  // Works out the acknowledgement word for one frame header and moves the
  // predicted window along.
  function automatic result_t predict_ack(input logic [SEQ_W-1:0] seq, input logic good,
                                          input logic fin);
    result_t res;
    int      r;
    int      w;
    int      moved;
    bit      in_win;
    bit      have;
    r = active_range();
    w = active_window(r);
    in_win = slot_in_window(int'(seq), r);
    have = in_win && seen_map[seq];
    res = '0;

    // A damaged frame for an empty slot inside the window gets no answer. Outside
    // the window, go-back-N repeats the last in-order number instead.
    if (in_win) begin
      if (good || have) begin
        res.ack_valid = 1'b1;
        res.ack_seq = seq;
      end
    end else begin
      res.ack_valid = 1'b1;
      if (gbn_mode) begin
        res.ack_seq = (win_base == '0) ? SEQ_W'(r - 1) : SEQ_W'(win_base - 1'b1);
      end else begin
        res.ack_seq = seq;
      end
    end

    if (good && in_win && !have) begin
      seen_map[seq] = 1'b1;
      res.stored = 1'b1;
      if (stored_total != '1) stored_total = stored_total + 1'b1;
      if (fin) begin
        last_seq = seq;
        last_seen = 1'b1;
      end
    end else if (repeat_total != '1) begin
      repeat_total = repeat_total + 1'b1;
    end

    // Slide over the run of received slots, at most one window per frame.
    moved = 0;
    while (moved < w && seen_map[win_base]) begin
      seen_map[win_base] = 1'b0;
      win_base = SEQ_W'((int'(win_base) + 1) % r);
      win_top = SEQ_W'((int'(win_top) + 1) % r);
      moved++;
    end

    if (last_seen && !slot_in_window(int'(last_seq), r)) done_seen = 1'b1;

    res.slots_released  = WIN_W'(moved);
    res.window_base_out = win_base;
    res.transfer_done   = done_seen;
    res.original_count  = stored_total;
    res.repeat_count    = repeat_total;
    return res;
  endfunction

  // Printing stops after a while so that a badly broken block cannot flood the
  // log, but every mismatch is still counted.
  task automatic report_error(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("ERROR at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) report_error($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  // Draws a frame header the way a real sender produces them: mostly numbers in
  // or just past the current window, some retransmissions of frames already
  // slid past, and some arbitrary numbers, including ones beyond the range.
  function automatic void pick_frame(output logic [SEQ_W-1:0] seq, output logic good,
                                     output logic fin);
    int r;
    int w;
    int pick;
    r = active_range();
    w = active_window(r);
    pick = int'($urandom_range(99));
    if (pick < 60) begin
      seq = SEQ_W'((int'(win_base) + int'($urandom_range(w))) % r);
    end else if (pick < 80) begin
      seq = SEQ_W'((int'(win_base) + r - 1 - int'($urandom_range(w - 1))) % r);
    end else begin
      seq = SEQ_W'($urandom_range(SEQ_SLOTS - 1));
    end
    good = ($urandom_range(99) < 85);
    fin = ($urandom_range(99) < 2);
  endfunction

  // Offers one frame word, starting and ending on a falling edge. Valid stays
  // high on return so that back-to-back words need no gap; callers lower it.
  task automatic send_frame(input logic [SEQ_W-1:0] seq, input logic good, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      frame_if.valid <= 1'b0;
      @(negedge clk);
    end
    frame_if.valid       <= 1'b1;
    frame_if.frame_seq   <= seq;
    frame_if.frame_good  <= good;
    frame_if.final_frame <= fin;
    do @(posedge clk); while (frame_if.ready !== 1'b1);
    expected_acks.push_back(predict_ack(seq, good, fin));
    @(negedge clk);
  endtask

  task automatic run_random_frames(input int count);
    logic [SEQ_W-1:0] seq;
    logic             good;
    logic             fin;
    repeat (count) begin
      pick_frame(seq, good, fin);
      send_frame(seq, good, fin);
    end
  endtask

  // Stops offering frames and waits until every owed word has come back. It
  // always passes at least one falling edge, so valid is never lowered and
  // raised again in the same step.
  task automatic wait_drained();
    frame_if.valid <= 1'b0;
    do @(negedge clk); while (expected_acks.size() != 0);
  endtask

  // Register write on the configuration channel; valid is left high for a
  // following write and the caller lowers it after the last one.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    apply_register(idx, data);
    @(negedge clk);
  endtask

  task automatic configure_link(input logic [CFG_DAT_W-1:0] mode,
                                input logic [CFG_DAT_W-1:0] win,
                                input logic [CFG_DAT_W-1:0] rng);
    wait_drained();
    write_register(CFG_GO_BACK_N, mode);
    write_register(CFG_WINDOW, win);
    write_register(CFG_RANGE, rng);
    cfg_if.valid <= 1'b0;
  endtask

  // Hand-picked frames from the reset setting (selective repeat, window 7,
  // range 20), then a short go-back-N stretch that wraps the base to zero.
  task automatic test_directed_cases();
    send_frame(5'd0, 1'b1, 1'b0);    // in-order frame, window slides one slot
    send_frame(5'd2, 1'b1, 1'b0);    // out of order, held behind a gap
    send_frame(5'd2, 1'b1, 1'b0);    // duplicate inside the window
    send_frame(5'd3, 1'b0, 1'b0);    // damaged frame for an empty slot, no answer
    send_frame(5'd2, 1'b0, 1'b0);    // damaged frame for a filled slot is acked
    send_frame(5'd1, 1'b1, 1'b0);    // fills the gap, slides two slots
    send_frame(5'd19, 1'b1, 1'b0);   // behind the window, acked with its own number
    send_frame(5'd25, 1'b1, 1'b0);   // beyond the sequence range
    send_frame(5'd31, 1'b0, 1'b1);   // largest number, damaged, last-frame flag set
    send_frame(5'd5, 1'b1, 1'b1);    // last frame stored but still inside the window
    send_frame(5'd3, 1'b1, 1'b0);
    send_frame(5'd4, 1'b1, 1'b0);    // last frame leaves the window, done rises
    send_frame(5'd12, 1'b1, 1'b0);   // top edge of the window
    send_frame(5'd13, 1'b1, 1'b0);   // one past the top edge
    for (int s = 7; s <= 11; s++) send_frame(SEQ_W'(s), 1'b1, 1'b0);
    send_frame(5'd6, 1'b1, 1'b0);    // releases a full window in one frame

    wait_drained();
    write_register(CFG_GO_BACK_N, 6'd1);
    cfg_if.valid <= 1'b0;
    send_frame(5'd14, 1'b1, 1'b0);   // ahead of the base, last in-order number comes back
    send_frame(5'd13, 1'b1, 1'b0);

    // A range of three folds the base down and leaves a window of one.
    wait_drained();
    write_register(CFG_RANGE, 6'd3);
    cfg_if.valid <= 1'b0;
    send_frame(5'd2, 1'b1, 1'b0);    // base wraps to zero
    send_frame(5'd1, 1'b1, 1'b0);    // base zero, answer is range minus one
    send_frame(5'd31, 1'b1, 1'b0);
  endtask

  // Widest window: range register at its top (clamped to 32) and a window value
  // whose upper bits are dropped, giving fifteen slots and the longest slides.
  task automatic test_wide_window();
    configure_link(6'd0, 6'd63, 6'd63);
    run_random_frames(200);
  endtask

  // Zero window and zero range are raised to one slot out of three numbers.
  task automatic test_minimum_range();
    configure_link(6'd0, 6'd0, 6'd0);
    run_random_frames(100);
  endtask

  task automatic test_go_back_n();
    configure_link(6'd1, 6'd15, 6'd32);
    run_random_frames(150);
  endtask

  task automatic test_mid_window();
    configure_link(6'd0, 6'd9, 6'd20);
    run_random_frames(150);
  endtask

  // A window of twelve in a range of eleven is cut down to five slots.
  task automatic test_clamped_window();
    configure_link(6'd62, 6'd12, 6'd11);
    run_random_frames(170);
  endtask

  // The receiver holds off while frames keep coming, so the output register
  // fills and the block must stall its input. Afterwards the sender waits for
  // every owed word before carrying on.
  task automatic test_stalled_receiver();
    configure_link(6'd0, 6'd6, 6'd17);
    @(posedge clk);
    hold_off_request = 1'b1;
    @(negedge clk);
    run_random_frames(40);
    wait_drained();
    run_random_frames(100);
  endtask

  task automatic test_unused_register();
    wait_drained();
    write_register(CFG_UNUSED_INDEX, CFG_DAT_W'($urandom_range(63)));
    cfg_if.valid <= 1'b0;
    run_random_frames(25);
  endtask

  // Result side: ready toggles at the falling edge, at random or held low for
  // the requested stretch.
  always @(negedge clk) begin
    if (hold_off_request) begin
      hold_off_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      ack_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      ack_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each accepted acknowledgement word is checked against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && ack_if.valid === 1'b1 && ack_if.ready === 1'b1) begin
      if (expected_acks.size() == 0) begin
        report_error($sformatf("ack word for seq %0d with no frame outstanding",
                               ack_if.ack_seq));
      end else begin
        want = expected_acks.pop_front();
        check_field("ack_valid", 32'(want.ack_valid), 32'(ack_if.ack_valid));
        check_field("ack_seq", 32'(want.ack_seq), 32'(ack_if.ack_seq));
        check_field("stored", 32'(want.stored), 32'(ack_if.stored));
        check_field("slots_released", 32'(want.slots_released),
                    32'(ack_if.slots_released));
        check_field("window_base_out", 32'(want.window_base_out),
                    32'(ack_if.window_base_out));
        check_field("transfer_done", 32'(want.transfer_done), 32'(ack_if.transfer_done));
        check_field("original_count", want.original_count, ack_if.original_count);
        check_field("repeat_count", want.repeat_count, ack_if.repeat_count);
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((frame_if.valid & frame_if.ready) === 1'b1 || (ack_if.valid & ack_if.ready) === 1'b1 ||
        (cfg_if.valid & cfg_if.ready) === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout after %0d cycles without a handshake", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n                = 1'b0;
    frame_if.valid       = 1'b0;
    frame_if.frame_seq   = '0;
    frame_if.frame_good  = 1'b0;
    frame_if.final_frame = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CFG_GO_BACK_N;
    cfg_if.data          = '0;
    ack_if.ready         = 1'b0;
    mismatch_count       = 0;
    quiet_cycles         = 0;
    hold_off_request     = 1'b0;
    hold_left            = 0;
    reset_window_model();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // First the sender rarely idles while the receiver often stalls.
    send_idle_pct  = 15;
    recv_stall_pct = 76;
    test_directed_cases();
    test_wide_window();
    test_minimum_range();

    // Then the other way round.
    send_idle_pct  = 76;
    recv_stall_pct = 15;
    test_go_back_n();
    test_mid_window();

    // Then both sides run flat out.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_clamped_window();
    test_stalled_receiver();
    test_unused_register();

    // Let any stray word show up before the verdict.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_acks.size() != 0) begin
      report_error($sformatf("%0d ack words never arrived", expected_acks.size()));
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/swr_pkg.sv
rtl/swr_intf.sv
rtl/sliding_window_receiver.sv
sim/tb.sv
